// ===== rtl/core/srb_pkg.sv =====
// shared types, constants and pointer helpers for the serial rx/tx ring buffer
// no dependencies; imported by srb_front, srb_back and the top level

package srb_pkg;

  localparam int RX_DEPTH = 512;
  localparam int TX_DEPTH = 512;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);

  // front-to-back command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef enum logic [1:0] {
    CMD_LINE_RX = 2'd0,
    CMD_HOST_RD = 2'd1,
    CMD_HOST_WR = 2'd2,
    CMD_TX_TICK = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_in;
    logic       last_in_burst;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       accepted;
    logic       tx_irq_enable;
    logic       rx_empty;
    logic       tx_full;
    logic       wake_reader;
    logic       wake_writer;
  } out_beat_t;

  // classified command handed from front to back
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       last;
    logic       pair;
  } op_t;

  function automatic logic [RX_AW-1:0] rx_inc(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_AW-1:0] tx_inc(input logic [TX_AW-1:0] p);
    return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [QUEUE_AW-1:0] q_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== rtl/core/srb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/srb_front.sv =====
// front end: takes input beats, classifies them and queues them for the back end
// depends on srb_pkg

module srb_front
  import srb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     expand,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     q_valid,
  output op_t      q_item,
  input  logic     q_pop
);

  op_t                 q_mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] q_wptr_r;
  logic [QUEUE_AW-1:0] q_rptr_r;
  logic [QUEUE_CW-1:0] q_cnt_r;
  logic                push;
  op_t                 op_new;

  assign in_ready = (q_cnt_r != QUEUE_CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != '0);
  assign q_item   = q_mem_r[q_rptr_r];

  // a line feed written while expansion is on needs a cr lf pair
  always_comb begin
    op_new.cmd  = cmd_t'(in_data.cmd);
    op_new.data = in_data.data_in;
    op_new.last = in_data.last_in_burst;
    op_new.pair = expand && (in_data.data_in == CH_LF);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wptr_r] <= op_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wptr_r <= '0;
      q_rptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (push) begin
        q_wptr_r <= q_inc(q_wptr_r);
      end
      if (q_pop) begin
        q_rptr_r <= q_inc(q_rptr_r);
      end
      if (push && !q_pop) begin
        q_cnt_r <= q_cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        q_cnt_r <= q_cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/srb_back.sv =====
// back end: ring pointers, both byte stores, command sequencer and result register
// depends on srb_pkg and srb_ram

module srb_back
  import srb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH2,
    ST_FIN
  } state_t;

  state_t           state_r;
  op_t              cur_r;
  out_beat_t        res_r;
  out_beat_t        out_r;
  logic             out_valid_r;
  logic [RX_AW-1:0] rx_wr_ptr_r;
  logic [RX_AW-1:0] rx_rd_ptr_r;
  logic [TX_AW-1:0] tx_wr_ptr_r;
  logic [TX_AW-1:0] tx_rd_ptr_r;
  logic             irq_r;
  logic             refused_r;

  logic [RX_AW-1:0] rx_wr_p1;
  logic [TX_AW-1:0] tx_wr_p1;
  logic [TX_AW-1:0] tx_wr_p2;
  logic             rx_full;
  logic             rx_empty;
  logic             tx_full;
  logic             tx_empty;
  logic             tx_fits;
  logic             rx_we;
  logic             tx_we;
  logic [7:0]       tx_wdata;
  logic [7:0]       rx_rdata;
  logic [7:0]       tx_rdata;
  out_beat_t        exec_res;
  out_beat_t        fin_res;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign q_pop     = (state_r == ST_IDLE) && q_valid && (!out_valid_r || out_ready);

  always_comb begin
    rx_wr_p1 = rx_inc(rx_wr_ptr_r);
    tx_wr_p1 = tx_inc(tx_wr_ptr_r);
    tx_wr_p2 = tx_inc(tx_wr_p1);
    rx_full  = (rx_wr_p1 == rx_rd_ptr_r);
    rx_empty = (rx_wr_ptr_r == rx_rd_ptr_r);
    tx_full  = (tx_wr_p1 == tx_rd_ptr_r);
    tx_empty = (tx_wr_ptr_r == tx_rd_ptr_r);
    tx_fits  = cur_r.pair ? (!tx_full && (tx_wr_p2 != tx_rd_ptr_r)) : !tx_full;
    rx_we    = (state_r == ST_EXEC) && (cur_r.cmd == CMD_LINE_RX) && !rx_full;
    tx_we    = ((state_r == ST_EXEC) && (cur_r.cmd == CMD_HOST_WR) && !refused_r && tx_fits)
               || (state_r == ST_PUSH2);
    tx_wdata = ((state_r == ST_EXEC) && cur_r.pair) ? CH_CR : cur_r.data;
  end

  // result fields of the command in the exec cycle
  always_comb begin
    exec_res = '0;
    case (cur_r.cmd)
      CMD_LINE_RX: begin
        exec_res.accepted    = !rx_full;
        exec_res.wake_reader = !rx_full;
      end
      CMD_HOST_RD: begin
        if (!rx_empty) begin
          exec_res.data_out   = rx_rdata;
          exec_res.data_valid = 1'b1;
        end
      end
      CMD_HOST_WR: begin
        exec_res.accepted = !refused_r && tx_fits;
      end
      CMD_TX_TICK: begin
        if (!tx_empty) begin
          exec_res.data_out    = tx_rdata;
          exec_res.data_valid  = 1'b1;
          exec_res.wake_writer = 1'b1;
        end
      end
      default: begin
        exec_res = '0;
      end
    endcase
  end

  // flags are taken once every pointer of the step has moved
  always_comb begin
    fin_res               = res_r;
    fin_res.tx_irq_enable = irq_r;
    fin_res.rx_empty      = rx_empty;
    fin_res.tx_full       = tx_full;
  end

  // read ports sit on the read pointers; data is ready in the exec cycle
  srb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wr_ptr_r),
    .wdata (cur_r.data),
    .raddr (rx_rd_ptr_r),
    .rdata (rx_rdata)
  );

  srb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wr_ptr_r),
    .wdata (tx_wdata),
    .raddr (tx_rd_ptr_r),
    .rdata (tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rx_wr_ptr_r <= '0;
      rx_rd_ptr_r <= '0;
      tx_wr_ptr_r <= '0;
      tx_rd_ptr_r <= '0;
      irq_r       <= 1'b0;
      refused_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            cur_r   <= q_item;
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_r   <= exec_res;
          state_r <= (tx_we && cur_r.pair) ? ST_PUSH2 : ST_FIN;
          case (cur_r.cmd)
            CMD_LINE_RX: begin
              if (!rx_full) begin
                rx_wr_ptr_r <= rx_wr_p1;
              end
            end
            CMD_HOST_RD: begin
              if (!rx_empty) begin
                rx_rd_ptr_r <= rx_inc(rx_rd_ptr_r);
              end
            end
            CMD_HOST_WR: begin
              if (refused_r) begin
                if (cur_r.last) begin
                  refused_r <= 1'b0;
                end
              end else if (tx_fits) begin
                tx_wr_ptr_r <= tx_wr_p1;
                irq_r       <= 1'b1;
              end else if (!cur_r.last) begin
                refused_r <= 1'b1;
              end
            end
            CMD_TX_TICK: begin
              if (tx_empty) begin
                irq_r <= 1'b0;
              end else begin
                tx_rd_ptr_r <= tx_inc(tx_rd_ptr_r);
              end
            end
            default: begin
            end
          endcase
        end
        ST_PUSH2: begin
          // line feed after the carriage return
          tx_wr_ptr_r <= tx_wr_p1;
          state_r     <= ST_FIN;
        end
        ST_FIN: begin
          out_r       <= fin_res;
          out_valid_r <= 1'b1;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_push2_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH2 |-> $past(state_r) == ST_EXEC)
    else $error("second push without an accepted cr lf write");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !out_valid_r || out_ready)
    else $error("command taken while result register is blocked");

  a_rx_wr_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(rx_wr_ptr_r) |-> rx_wr_ptr_r == rx_inc($past(rx_wr_ptr_r)))
    else $error("rx write pointer moved by other than one slot");

  a_wake_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.wake_reader |-> out_r.accepted && !out_r.data_valid)
    else $error("reader wake without a stored byte");

endmodule

// ===== rtl/core/serial_rx_tx_ring_buffer.sv =====
// top level of the serial rx/tx ring buffer: config register, front end, back end
// depends on srb_pkg, srb_front, srb_back (and srb_ram through srb_back)

// Two byte rings of RX_DEPTH and TX_DEPTH slots (one slot always kept free)
// sit between a serial line and a host. Each input beat is one command: line
// byte received, host read, host write or transmitter-ready tick, and each
// gives exactly one result beat with the popped byte and the ring flags after
// the step. In the back end a beat is popped from the command queue, then the
// ring is accessed and the result built; a line feed written as cr lf takes an
// extra write step, as both bytes go through the one write port of the transmit
// ram. A two-beat command queue lets the input side keep taking beats while a
// result waits for out_ready. newline_expand resets to 1; the user must write it
// through the cfg channel only while the block is idle, which the block does not
// enforce. No clearing pass: ram starts undefined and only stored bytes are read.

module serial_rx_tx_ring_buffer
  import srb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic expand_r;
  logic q_valid;
  logic q_pop;
  op_t  q_item;

  // config beats are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expand_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      expand_r <= cfg_data;
    end
  end

  // front classifies beats (line feed pair detection) and queues them
  srb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .expand   (expand_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back runs the rings and holds the result register
  srb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== bench/serial_rx_tx_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for serial_rx_tx_ring_buffer: directed and random command beats,
// each result beat checked against an in-bench model of both byte rings
// depends on srb_pkg and the block rtl only

module serial_rx_tx_ring_buffer_tb;
  import srb_pkg::*;

  // generous run limit, far above the slowest legal run of about 1500 beats
  localparam int CYCLE_LIMIT  = 400000;
  // cycles to linger after the last result, enough to catch a stray extra beat
  localparam int DRAIN_CYCLES = 64;
  // longest idle gap or stall either side draws for one beat
  localparam int MAX_WAIT     = 17;
  localparam int REPORT_LIMIT = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  serial_rx_tx_ring_buffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // ring model: two byte rings, one slot always left free, plus the irq enable,
  // the burst refusal hold and the newline expansion setting
  // ---------------------------------------------------------------------------
  logic [7:0]       rx_bytes [RX_DEPTH];
  logic [7:0]       tx_bytes [TX_DEPTH];
  logic [RX_AW-1:0] rx_tail;    // next rx slot to fill
  logic [RX_AW-1:0] rx_head;    // next rx slot to pop
  logic [TX_AW-1:0] tx_tail;
  logic [TX_AW-1:0] tx_head;
  logic             irq_en;
  logic             refusing;   // set by a refused write mid-burst
  logic             expand_lf;  // mirror of the newline_expand register

  // result beats still owed by the block, oldest first
  out_beat_t pending_results [$];

  int unsigned mismatches;
  int unsigned cycles;
  bit          in_quiet;      // stretches with back-to-back input beats
  bit          out_quiet;     // stretches with out_ready held high

  function automatic logic [RX_AW-1:0] rx_after(input logic [RX_AW-1:0] p);
    return RX_AW'((int'(p) + 1) % RX_DEPTH);
  endfunction

  function automatic logic [TX_AW-1:0] tx_after(input logic [TX_AW-1:0] p);
    return TX_AW'((int'(p) + 1) % TX_DEPTH);
  endfunction

  function automatic int tx_fill();
    return (int'(tx_tail) + TX_DEPTH - int'(tx_head)) % TX_DEPTH;
  endfunction

  // advance the model by one accepted command beat and return the result beat
  function automatic out_beat_t next_ring_result(input in_beat_t b);
    out_beat_t r;
    logic      pair;
    int        room;
    r = '0;
    case (cmd_t'(b.cmd))
      CMD_LINE_RX: begin
        // byte from the line, dropped silently when the rx ring is full
        if (rx_after(rx_tail) != rx_head) begin
          rx_bytes[rx_tail] = b.data_in;
          rx_tail = rx_after(rx_tail);
          r.accepted = 1'b1;
          r.wake_reader = 1'b1;
        end
      end
      CMD_HOST_RD: begin
        // read of an empty rx ring returns nothing
        if (rx_tail != rx_head) begin
          r.data_out = rx_bytes[rx_head];
          r.data_valid = 1'b1;
          rx_head = rx_after(rx_head);
        end
      end
      CMD_HOST_WR: begin
        if (refusing) begin
          // every write of the burst is refused; the closing beat ends the hold
          if (b.last_in_burst) refusing = 1'b0;
        end else begin
          pair = expand_lf && (b.data_in == CH_LF);
          room = TX_DEPTH - 1 - tx_fill();
          if (room >= (pair ? 2 : 1)) begin
            // cr lf goes in whole or not at all
            if (pair) begin
              tx_bytes[tx_tail] = CH_CR;
              tx_tail = tx_after(tx_tail);
            end
            tx_bytes[tx_tail] = b.data_in;
            tx_tail = tx_after(tx_tail);
            irq_en = 1'b1;
            r.accepted = 1'b1;
          end else if (!b.last_in_burst) begin
            refusing = 1'b1;
          end
        end
      end
      default: begin
        // transmitter tick: pop a byte, or drop the enable once the ring is empty
        if (tx_tail == tx_head) begin
          irq_en = 1'b0;
        end else begin
          r.data_out = tx_bytes[tx_head];
          r.data_valid = 1'b1;
          r.wake_writer = 1'b1;
          tx_head = tx_after(tx_head);
        end
      end
    endcase
    r.tx_irq_enable = irq_en;
    r.rx_empty = (rx_tail == rx_head);
    r.tx_full = (tx_fill() == TX_DEPTH - 1);
    return r;
  endfunction

  // host bytes lean toward line feeds so the cr lf path gets real traffic
  function automatic logic [7:0] host_byte();
    return ($urandom_range(0, 4) == 0) ? CH_LF : 8'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input side: one command beat per call, random gap first. valid stays high
  // after the handshake; the next call (or the caller) lowers it in the same
  // time step when no beat follows at once
  // ---------------------------------------------------------------------------
  task automatic send_beat(input cmd_t c, input logic [7:0] d, input logic last);
    int gap;
    if ($urandom_range(0, 49) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: c, data_in: d, last_in_burst: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(next_ring_result(in_data));
  endtask

  // newline_expand is only touched with nothing in flight
  task automatic write_expand(input logic v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    expand_lf = v;
  endtask

  // random command mix: read_tick_pct percent reads and ticks, the rest rx and writes
  task automatic send_mixed(input int read_tick_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < read_tick_pct) begin
      send_beat((r % 2 == 0) ? CMD_HOST_RD : CMD_TX_TICK, 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end else if (r % 2 == 0) begin
      send_beat(CMD_LINE_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_beat(CMD_HOST_WR, host_byte(), $urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall before each beat, then check it field by field
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want_v, got_v);
    end
  endtask

  initial begin : result_checker
    out_beat_t want;
    int        stall;
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
      stall = out_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result beat %0h with none expected", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("data_out", want.data_out, out_data.data_out);
        check_field("data_valid", want.data_valid, out_data.data_valid);
        check_field("accepted", want.accepted, out_data.accepted);
        check_field("tx_irq_enable", want.tx_irq_enable, out_data.tx_irq_enable);
        check_field("rx_empty", want.rx_empty, out_data.rx_empty);
        check_field("tx_full", want.tx_full, out_data.tx_full);
        check_field("wake_reader", want.wake_reader, out_data.wake_reader);
        check_field("wake_writer", want.wake_writer, out_data.wake_writer);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // read and tick on rings that never held a byte
  task automatic test_empty_pops();
    send_beat(CMD_HOST_RD, 8'h5A, 1'b0);
    send_beat(CMD_TX_TICK, 8'hA5, 1'b1);
  endtask

  // extreme line bytes in, popped in order, then a read past the end
  task automatic test_rx_basic();
    send_beat(CMD_LINE_RX, 8'h00, 1'b0);
    send_beat(CMD_LINE_RX, 8'hFF, 1'b1);
    send_beat(CMD_HOST_RD, 8'hFF, 1'b0);
    send_beat(CMD_HOST_RD, 8'h00, 1'b1);
    send_beat(CMD_HOST_RD, 8'h0A, 1'b0);
  endtask

  // with expansion on a line feed goes out as cr lf; the final tick on an
  // empty ring clears the irq enable
  task automatic test_tx_newline();
    send_beat(CMD_HOST_WR, 8'hFF, 1'b1);
    send_beat(CMD_HOST_WR, CH_LF, 1'b0);
    send_beat(CMD_HOST_WR, 8'h00, 1'b1);
    repeat (5) send_beat(CMD_TX_TICK, 8'h00, 1'b0);
  endtask

  // expansion off: line feed stored as a single byte
  task automatic test_expand_off();
    write_expand(1'b0);
    send_beat(CMD_HOST_WR, CH_LF, 1'b1);
    send_beat(CMD_HOST_WR, CH_CR, 1'b1);
    repeat (3) send_beat(CMD_TX_TICK, 8'hFF, 1'b1);
    write_expand(1'b1);
  endtask

  // flood the rx ring well past full so bytes get dropped, a few pops mixed in
  task automatic test_rx_overflow();
    int pick;
    for (int i = 0; i < 560; i++) begin
      pick = $urandom_range(0, 63);
      if (pick == 0)
        send_beat(CMD_HOST_RD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick == 1)
        send_beat(CMD_TX_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      else if (pick == 2)
        send_beat(CMD_HOST_WR, host_byte(), 1'b1);
      else
        send_beat(CMD_LINE_RX, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // write bursts until the tx ring fills, then refusals, the hold and its release;
  // rare ticks free single slots so cr lf pairs meet a one-slot gap.
  // some bursts are cut short by a stray last flag
  task automatic test_tx_refusal();
    int sent;
    int len;
    sent = 0;
    while (sent < 520) begin
      len = $urandom_range(1, 20);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 47) == 0) begin
          send_beat(CMD_TX_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end
        send_beat(CMD_HOST_WR, host_byte(), (k == len - 1) || ($urandom_range(0, 15) == 0));
        sent++;
      end
    end
  endtask

  // even mix of all commands around full rings, expansion off
  task automatic test_mixed_traffic();
    write_expand(1'b0);
    repeat (170) send_mixed(50);
  endtask

  // mostly reads and ticks to pull both rings down, expansion back on
  task automatic test_ring_drain();
    write_expand(1'b1);
    repeat (170) send_mixed(90);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    rx_tail = '0;
    rx_head = '0;
    tx_tail = '0;
    tx_head = '0;
    irq_en = 1'b0;
    refusing = 1'b0;
    expand_lf = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // register starts at 1; write it anyway so the port sees both values
    write_expand(1'b1);
    test_empty_pops();
    test_rx_basic();
    test_tx_newline();
    test_expand_off();
    test_rx_overflow();
    test_tx_refusal();
    test_mixed_traffic();
    test_ring_drain();

    // settle: every owed beat in, then a short window for anything extra
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== serial_rx_tx_ring_buffer.f =====
rtl/core/srb_pkg.sv
rtl/core/srb_ram.sv
rtl/core/srb_front.sv
rtl/core/srb_back.sv
rtl/core/serial_rx_tx_ring_buffer.sv
bench/serial_rx_tx_ring_buffer_tb.sv
